[src/assert_macros.svh]
// Assertion helpers used by the accumulator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// pre holds -> post holds in the same cycle
`define ASSERT_IMP(lbl, clk_s, rst_s, pre, post) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (pre) |-> (post)) \
        else $error("assertion failed");
// pre holds -> post holds in the next cycle
`define ASSERT_NXT(lbl, clk_s, rst_s, pre, post) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk_s, rst_s, pre, post)
`define ASSERT_NXT(lbl, clk_s, rst_s, pre, post)
`endif
`endif

[src/fqva_pkg.sv]
package fqva_pkg;

    localparam int MAX_ORDERS   = 8;
    localparam int NUM_BINS     = 64;
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN     = 24;
    localparam int CORDIC_ITER  = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
    localparam int LOG_FRAC     = 20;

    localparam int ORD_W      = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;
    localparam int ORD_CNT_W  = $clog2(MAX_ORDERS + 1);
    localparam int BIN_W      = $clog2(NUM_BINS);
    localparam int ACC_DEPTH  = MAX_ORDERS * NUM_BINS;
    localparam int ACC_ADDR_W = $clog2(ACC_DEPTH);

    localparam logic [29:0] LN2_Q30       = 30'd744261118;
    localparam logic [29:0] GAIN_COMP_Q30 = 30'd652032874;

    localparam logic [1:0] FUNC_ACC   = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;
    localparam logic [1:0] FUNC_NONE  = 2'd3;

    localparam logic [2:0] CFG_RAPIDITY_MODE = 3'd0;
    localparam logic [2:0] CFG_RAPIDITY_LOW  = 3'd1;
    localparam logic [2:0] CFG_RAPIDITY_HIGH = 3'd2;
    localparam logic [2:0] CFG_PT_LOW        = 3'd3;
    localparam logic [2:0] CFG_PT_HIGH       = 3'd4;
    localparam logic [2:0] CFG_INV_BIN_WIDTH = 3'd5;
    localparam logic [2:0] CFG_ORDERS_IN_USE = 3'd6;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [23:0] mom_x;
        logic signed [23:0] mom_y;
        logic signed [23:0] mom_z;
        logic [23:0]        energy;
        logic [23:0]        rest_mass;
        logic [2:0]         read_order;
        logic [5:0]         read_bin;
    } in_item_t;

    typedef struct packed {
        logic               accepted;
        logic [5:0]         bin_index;
        logic signed [39:0] total_real;
        logic signed [39:0] total_imag;
        logic signed [39:0] bin_real;
        logic signed [39:0] bin_imag;
    } out_item_t;

    // atan(2^-i) as a 32-bit binary angle
    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

[src/flow_qvector_accumulator.sv]
// Harmonic flow Qn-vector accumulator.
// Input channel (in_valid/in_stall/in_data) carries one item with a func code:
//   accumulate a particle, read one order/bin of the sums, or clear all sums.
// Output channel (out_valid/out_stall/out_data) returns exactly one item per
//   input item, in order. The configuration port (cfg_write/cfg_index/cfg_data)
//   is a plain write port; the user must use it only while the block is idle.
// Items are handled one at a time: in_stall is high until the current item has
//   been placed in the output register. The output register lets the next item
//   be taken while a result still waits on out_stall.
// Accumulate is stepped by the sequencer: two 24-step square roots (one in
//   energy mode), two log2 passes (up to 31 normalize steps plus 20 squarings
//   each), the 16-step atan2 CORDIC, then for each order above zero a 16-step
//   sin/cos CORDIC, and for every order a read-modify-write on the binned sum
//   RAM. Rejected particles leave early.
// All multiplies share one 32x32 multiplier with a registered product.
// After reset the block sweeps the binned RAM to zero and keeps in_stall high
//   meanwhile; configuration writes are taken throughout, unchecked by the block.
// A stall on the output only holds the finished item; the sequencer waits in
//   its final state until the output register is free.
`include "assert_macros.svh"

module flow_qvector_accumulator (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  fqva_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output fqva_pkg::out_item_t out_data,
    input  logic                cfg_write,
    input  logic [2:0]          cfg_index,
    input  logic [23:0]         cfg_data
);

    import fqva_pkg::*;

    localparam logic [4:0] ST_INIT      = 5'd0;
    localparam logic [4:0] ST_IDLE      = 5'd1;
    localparam logic [4:0] ST_SQ_E      = 5'd2;
    localparam logic [4:0] ST_SQ_M      = 5'd3;
    localparam logic [4:0] ST_SUB_EM    = 5'd4;
    localparam logic [4:0] ST_SQRT      = 5'd5;
    localparam logic [4:0] ST_CHK       = 5'd6;
    localparam logic [4:0] ST_NORM      = 5'd7;
    localparam logic [4:0] ST_LMUL      = 5'd8;
    localparam logic [4:0] ST_LSQ       = 5'd9;
    localparam logic [4:0] ST_RAP_MUL   = 5'd10;
    localparam logic [4:0] ST_RAP       = 5'd11;
    localparam logic [4:0] ST_PT_X      = 5'd12;
    localparam logic [4:0] ST_PT_Y      = 5'd13;
    localparam logic [4:0] ST_PT_SUM    = 5'd14;
    localparam logic [4:0] ST_PT_CHK    = 5'd15;
    localparam logic [4:0] ST_BIN       = 5'd16;
    localparam logic [4:0] ST_ATAN      = 5'd17;
    localparam logic [4:0] ST_ORD_START = 5'd18;
    localparam logic [4:0] ST_SC        = 5'd19;
    localparam logic [4:0] ST_SC_END    = 5'd20;
    localparam logic [4:0] ST_ORD_WR    = 5'd21;
    localparam logic [4:0] ST_RD        = 5'd22;
    localparam logic [4:0] ST_CLR       = 5'd23;
    localparam logic [4:0] ST_DONE      = 5'd24;

    // configuration
    logic               mode_reg;
    logic signed [23:0] y_low_reg;
    logic signed [23:0] y_high_reg;
    logic [23:0]        pt_low_reg;
    logic [23:0]        pt_high_reg;
    logic [23:0]        ibw_reg;
    logic [3:0]         orders_reg;

    // sequencer and item
    logic [4:0]         state_reg;
    logic [4:0]         cnt_reg;
    logic [1:0]         func_reg;
    logic signed [23:0] px_reg;
    logic signed [23:0] py_reg;
    logic signed [23:0] pz_reg;
    logic [23:0]        e_reg;
    logic [23:0]        m_reg;
    logic [2:0]         ro_reg;
    logic [5:0]         rb_reg;
    logic               acc_ok_reg;

    // shared multiplier
    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [63:0]        prod_reg;
    logic [47:0]        tmp_reg;

    // square root
    logic [47:0]        sq_in_reg;
    logic [25:0]        sq_rem_reg;
    logic [23:0]        sq_root_reg;
    logic               sq_pt_reg;
    logic [27:0]        rem_shift;
    logic [27:0]        trial;
    logic               sq_take;
    logic [23:0]        root_step;
    logic [23:0]        a_reg;
    logic [23:0]        pt_reg;

    // log2
    logic [31:0]        lm_reg;
    logic [4:0]         lk_reg;
    logic [LOG_FRAC-1:0] lfrac_reg;
    logic               lpass_reg;
    logic [24:0]        lnum_reg;
    logic [24:0]        lden_reg;
    logic [24:0]        dmag_reg;
    logic               dneg_reg;
    logic [31:0]        mm;
    logic [LOG_FRAC-1:0] frac_step;
    logic [24:0]        lg_val;
    logic signed [25:0] ldiff;

    // rapidity and window checks
    logic [23:0]        apz;
    logic [24:0]        num_sum;
    logic [24:0]        den_diff;
    logic [56:0]        rap_round;
    logic [20:0]        rap_mag;
    logic signed [25:0] rap_y;
    logic signed [25:0] y_low26;
    logic signed [25:0] y_high26;
    logic [23:0]        abs_px;
    logic [23:0]        abs_py;
    logic [15:0]        bin_raw;

    // CORDIC
    logic signed [35:0] cx_reg;
    logic signed [35:0] cy_reg;
    logic signed [33:0] cz_reg;
    logic signed [35:0] sh_x;
    logic signed [35:0] sh_y;
    logic signed [33:0] at_ext;
    logic signed [35:0] x0;
    logic signed [35:0] y0;
    logic signed [33:0] z_atan_next;
    logic [31:0]        phi_reg;
    logic [31:0]        ang_reg;
    logic               flip_reg;
    logic [31:0]        ang_fold;
    logic               ang_flip;

    // orders and accumulators
    logic [ORD_CNT_W-1:0] ord_reg;
    logic [ORD_CNT_W-1:0] norders;
    logic [BIN_W-1:0]   bin_reg;
    logic signed [16:0] term_c_reg;
    logic signed [16:0] term_s_reg;
    logic signed [39:0] tot_c_reg [MAX_ORDERS];
    logic signed [39:0] tot_s_reg [MAX_ORDERS];
    logic [ORD_W-1:0]   tot_idx;
    logic [ACC_ADDR_W-1:0] clr_addr_reg;
    logic [ACC_ADDR_W-1:0] ord_addr;

    // binned RAM
    logic               ram_we;
    logic [ACC_ADDR_W-1:0] ram_waddr;
    logic [79:0]        ram_wdata;
    logic               ram_re;
    logic [79:0]        ram_rdata;
    logic signed [39:0] rd_c;
    logic signed [39:0] rd_s;

    // output
    logic               out_valid_reg;
    out_item_t          out_data_reg;
    out_item_t          res;
    logic               out_free;

    function automatic logic signed [16:0] to_term(input logic signed [35:0] v);
        logic signed [36:0] r;
        logic signed [21:0] s;
        r = 37'(v) + 37'sd16384;
        s = 22'(r >>> 15);
        if (s > 22'sd32768)
        begin
            s = 22'sd32768;
        end
        else if (s < -22'sd32768)
        begin
            s = -22'sd32768;
        end
        return 17'(s);
    endfunction

    function automatic logic signed [39:0] sat40(input logic signed [39:0] a,
                                                 input logic signed [16:0] b);
        logic signed [40:0] s;
        s = 41'(a) + 41'(b);
        if (s > 41'sd549755813887)
        begin
            s = 41'sd549755813887;
        end
        else if (s < -41'sd549755813888)
        begin
            s = -41'sd549755813888;
        end
        return 40'(s);
    endfunction

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    assign norders = (int'(orders_reg) > MAX_ORDERS) ? ORD_CNT_W'(MAX_ORDERS)
                                                     : ORD_CNT_W'(orders_reg);
    assign tot_idx  = ORD_W'(ord_reg);
    assign ord_addr = ACC_ADDR_W'(int'(ord_reg) * NUM_BINS + int'(bin_reg));

    assign abs_px = px_reg[23] ? 24'(-px_reg) : 24'(px_reg);
    assign abs_py = py_reg[23] ? 24'(-py_reg) : 24'(py_reg);
    assign apz    = pz_reg[23] ? 24'(-pz_reg) : 24'(pz_reg);
    assign num_sum  = 25'({1'b0, a_reg}) + 25'(pz_reg);
    assign den_diff = 25'({1'b0, a_reg}) - 25'(pz_reg);

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_SQ_E:
            begin
                mul_a = 32'(e_reg);
                mul_b = 32'(e_reg);
            end
            ST_SQ_M:
            begin
                mul_a = 32'(m_reg);
                mul_b = 32'(m_reg);
            end
            ST_LMUL:
            begin
                mul_a = lm_reg;
                mul_b = lm_reg;
            end
            ST_RAP_MUL:
            begin
                mul_a = 32'(dmag_reg);
                mul_b = 32'(LN2_Q30);
            end
            ST_PT_X:
            begin
                mul_a = 32'(abs_px);
                mul_b = 32'(abs_px);
            end
            ST_PT_Y:
            begin
                mul_a = 32'(abs_py);
                mul_b = 32'(abs_py);
            end
            ST_PT_CHK:
            begin
                mul_a = 32'(24'(pt_reg - pt_low_reg));
                mul_b = 32'(ibw_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // one restoring square-root step
    assign rem_shift = {sq_rem_reg, sq_in_reg[47:46]};
    assign trial     = {2'b00, sq_root_reg, 2'b01};
    assign sq_take   = (rem_shift >= trial);
    assign root_step = {sq_root_reg[22:0], sq_take};

    // one log2 squaring step
    assign mm        = prod_reg[61:30];
    assign frac_step = {lfrac_reg[LOG_FRAC-2:0], mm[31]};
    assign lg_val    = 25'({lk_reg, frac_step});
    assign ldiff     = signed'({1'b0, lnum_reg}) - signed'({1'b0, lg_val});

    // rapidity: 0.5*ln2*d, rounded half away from zero
    assign rap_round = 57'(prod_reg[55:0]) + 57'h4_0000_0000;
    assign rap_mag   = rap_round[55:35];
    assign rap_y     = dneg_reg ? -signed'({5'b0, rap_mag}) : signed'({5'b0, rap_mag});
    assign y_low26   = signed'({{2{y_low_reg[23]}}, y_low_reg});
    assign y_high26  = signed'({{2{y_high_reg[23]}}, y_high_reg});

    assign bin_raw = prod_reg[47:32];

    // CORDIC step terms
    assign sh_x   = cx_reg >>> cnt_reg;
    assign sh_y   = cy_reg >>> cnt_reg;
    assign at_ext = signed'({2'b00, atan_entry(cnt_reg)});
    assign z_atan_next = cy_reg[35] ? (cz_reg - at_ext) : (cz_reg + at_ext);
    assign x0 = signed'({{4{px_reg[23]}}, px_reg, 8'b0});
    assign y0 = signed'({{4{py_reg[23]}}, py_reg, 8'b0});

    // fold n*phi into the right half-plane
    assign ang_flip = (ang_reg[31:30] == 2'd1) || (ang_reg[31:30] == 2'd2);
    assign ang_fold = ang_flip ? (ang_reg + 32'h8000_0000) : ang_reg;

    // binned RAM ports
    assign rd_c   = ram_rdata[79:40];
    assign rd_s   = ram_rdata[39:0];
    assign ram_we = (state_reg == ST_INIT) || (state_reg == ST_CLR) || (state_reg == ST_ORD_WR);
    assign ram_re = (state_reg == ST_ORD_START) || (state_reg == ST_RD);
    assign ram_waddr = ((state_reg == ST_INIT) || (state_reg == ST_CLR)) ? clr_addr_reg
                                                                         : ord_addr;
    assign ram_wdata = (state_reg == ST_ORD_WR) ? {sat40(rd_c, term_c_reg), sat40(rd_s, term_s_reg)}
                                                : '0;

    fqva_ram #(
        .WIDTH (80),
        .DEPTH (ACC_DEPTH)
    ) u_bin_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ord_addr),
        .rdata (ram_rdata)
    );

    // result assembly
    always_comb
    begin
        res = '0;
        if (func_reg == FUNC_READ)
        begin
            if (int'(ro_reg) < MAX_ORDERS)
            begin
                res.total_real = tot_c_reg[tot_idx];
                res.total_imag = tot_s_reg[tot_idx];
                if (int'(rb_reg) < NUM_BINS)
                begin
                    res.bin_real = rd_c;
                    res.bin_imag = rd_s;
                end
            end
        end
        else if (func_reg == FUNC_ACC)
        begin
            res.accepted  = acc_ok_reg;
            res.bin_index = acc_ok_reg ? 6'(bin_reg) : 6'd0;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= 1'b0;
            y_low_reg   <= -24'sd65536;
            y_high_reg  <= 24'sd65536;
            pt_low_reg  <= 24'd0;
            pt_high_reg <= 24'd196608;
            ibw_reg     <= 24'd1310720;
            orders_reg  <= 4'd8;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_RAPIDITY_MODE: mode_reg    <= cfg_data[0];
                CFG_RAPIDITY_LOW:  y_low_reg   <= signed'(cfg_data);
                CFG_RAPIDITY_HIGH: y_high_reg  <= signed'(cfg_data);
                CFG_PT_LOW:        pt_low_reg  <= cfg_data;
                CFG_PT_HIGH:       pt_high_reg <= cfg_data;
                CFG_INV_BIN_WIDTH: ibw_reg     <= cfg_data;
                CFG_ORDERS_IN_USE: orders_reg  <= cfg_data[3:0];
                default:
                begin
                end
            endcase
        end
    end

    // shared multiplier product register
    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(mul_a) * 64'(mul_b);
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
            acc_ok_reg    <= 1'b0;
            func_reg      <= FUNC_NONE;
            cnt_reg       <= '0;
            ord_reg       <= '0;
            for (int i = 0; i < MAX_ORDERS; i++)
            begin
                tot_c_reg[i] <= '0;
                tot_s_reg[i] <= '0;
            end
        end
        else
        begin
            // the final state reloads the output register itself
            if (out_valid_reg && !out_stall && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_INIT, ST_CLR:
                begin
                    for (int i = 0; i < MAX_ORDERS; i++)
                    begin
                        tot_c_reg[i] <= '0;
                        tot_s_reg[i] <= '0;
                    end
                    if (clr_addr_reg == ACC_ADDR_W'(ACC_DEPTH - 1))
                    begin
                        clr_addr_reg <= '0;
                        state_reg    <= (state_reg == ST_INIT) ? ST_IDLE : ST_DONE;
                    end
                    else
                    begin
                        clr_addr_reg <= clr_addr_reg + 1'b1;
                    end
                end

                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        func_reg   <= in_data.func;
                        px_reg     <= in_data.mom_x;
                        py_reg     <= in_data.mom_y;
                        pz_reg     <= in_data.mom_z;
                        e_reg      <= in_data.energy;
                        m_reg      <= in_data.rest_mass;
                        ro_reg     <= in_data.read_order;
                        rb_reg     <= in_data.read_bin;
                        acc_ok_reg <= 1'b0;
                        // a read uses the order/bin path of the accumulate loop
                        ord_reg    <= ORD_CNT_W'(in_data.read_order);
                        bin_reg    <= BIN_W'(in_data.read_bin);
                        unique case (in_data.func)
                            FUNC_ACC:   state_reg <= ST_SQ_E;
                            FUNC_READ:  state_reg <= ST_RD;
                            FUNC_CLEAR: state_reg <= ST_CLR;
                            FUNC_NONE:  state_reg <= ST_DONE;
                            default:    state_reg <= ST_DONE;
                        endcase
                    end
                end

                ST_SQ_E:
                begin
                    priority if (mode_reg)
                    begin
                        a_reg     <= e_reg;
                        state_reg <= ST_CHK;
                    end
                    else if (m_reg > e_reg)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        state_reg <= ST_SQ_M;
                    end
                end

                ST_SQ_M:
                begin
                    tmp_reg   <= prod_reg[47:0];
                    state_reg <= ST_SUB_EM;
                end

                ST_SUB_EM:
                begin
                    sq_in_reg   <= tmp_reg - prod_reg[47:0];
                    sq_rem_reg  <= '0;
                    sq_root_reg <= '0;
                    sq_pt_reg   <= 1'b0;
                    cnt_reg     <= 5'd23;
                    state_reg   <= ST_SQRT;
                end

                ST_SQRT:
                begin
                    sq_in_reg   <= {sq_in_reg[45:0], 2'b00};
                    sq_rem_reg  <= sq_take ? 26'(rem_shift - trial) : 26'(rem_shift);
                    sq_root_reg <= root_step;
                    cnt_reg     <= cnt_reg - 1'b1;
                    if (cnt_reg == 5'd0)
                    begin
                        if (sq_pt_reg)
                        begin
                            pt_reg    <= root_step;
                            state_reg <= ST_PT_CHK;
                        end
                        else
                        begin
                            a_reg     <= root_step;
                            state_reg <= ST_CHK;
                        end
                    end
                end

                ST_CHK:
                begin
                    if (a_reg <= apz)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        lm_reg    <= 32'(num_sum);
                        lden_reg  <= den_diff;
                        lk_reg    <= 5'd30;
                        lpass_reg <= 1'b0;
                        state_reg <= ST_NORM;
                    end
                end

                ST_NORM:
                begin
                    if (lm_reg[30])
                    begin
                        lfrac_reg <= '0;
                        cnt_reg   <= 5'(LOG_FRAC - 1);
                        state_reg <= ST_LMUL;
                    end
                    else
                    begin
                        lm_reg <= {lm_reg[30:0], 1'b0};
                        lk_reg <= lk_reg - 1'b1;
                    end
                end

                ST_LMUL:
                begin
                    state_reg <= ST_LSQ;
                end

                ST_LSQ:
                begin
                    lfrac_reg <= frac_step;
                    cnt_reg   <= cnt_reg - 1'b1;
                    if (cnt_reg != 5'd0)
                    begin
                        lm_reg    <= mm[31] ? {1'b0, mm[31:1]} : mm;
                        state_reg <= ST_LMUL;
                    end
                    else if (!lpass_reg)
                    begin
                        lnum_reg  <= lg_val;
                        lm_reg    <= 32'(lden_reg);
                        lk_reg    <= 5'd30;
                        lpass_reg <= 1'b1;
                        state_reg <= ST_NORM;
                    end
                    else
                    begin
                        dneg_reg  <= ldiff[25];
                        dmag_reg  <= ldiff[25] ? 25'(-ldiff) : 25'(ldiff);
                        state_reg <= ST_RAP_MUL;
                    end
                end

                ST_RAP_MUL:
                begin
                    state_reg <= ST_RAP;
                end

                ST_RAP:
                begin
                    state_reg <= ((rap_y > y_low26) && (rap_y < y_high26)) ? ST_PT_X : ST_DONE;
                end

                ST_PT_X:
                begin
                    state_reg <= ST_PT_Y;
                end

                ST_PT_Y:
                begin
                    tmp_reg   <= prod_reg[47:0];
                    state_reg <= ST_PT_SUM;
                end

                ST_PT_SUM:
                begin
                    sq_in_reg   <= tmp_reg + prod_reg[47:0];
                    sq_rem_reg  <= '0;
                    sq_root_reg <= '0;
                    sq_pt_reg   <= 1'b1;
                    cnt_reg     <= 5'd23;
                    state_reg   <= ST_SQRT;
                end

                ST_PT_CHK:
                begin
                    state_reg <= ((pt_reg > pt_low_reg) && (pt_reg < pt_high_reg)) ? ST_BIN
                                                                                   : ST_DONE;
                end

                ST_BIN:
                begin
                    bin_reg <= (int'(bin_raw) > NUM_BINS - 1) ? BIN_W'(NUM_BINS - 1)
                                                             : BIN_W'(bin_raw);
                    if (px_reg[23])
                    begin
                        cx_reg <= -x0;
                        cy_reg <= -y0;
                        cz_reg <= 34'sd2147483648;
                    end
                    else
                    begin
                        cx_reg <= x0;
                        cy_reg <= y0;
                        cz_reg <= '0;
                    end
                    cnt_reg   <= '0;
                    state_reg <= ST_ATAN;
                end

                ST_ATAN:
                begin
                    // vectoring: drive y toward zero
                    if (!cy_reg[35])
                    begin
                        cx_reg <= cx_reg + sh_y;
                        cy_reg <= cy_reg - sh_x;
                    end
                    else
                    begin
                        cx_reg <= cx_reg - sh_y;
                        cy_reg <= cy_reg + sh_x;
                    end
                    cz_reg  <= z_atan_next;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 5'(CORDIC_ITER - 1))
                    begin
                        phi_reg <= z_atan_next[31:0];
                        ang_reg <= '0;
                        ord_reg <= '0;
                        if (norders == '0)
                        begin
                            acc_ok_reg <= 1'b1;
                            state_reg  <= ST_DONE;
                        end
                        else
                        begin
                            state_reg <= ST_ORD_START;
                        end
                    end
                end

                ST_ORD_START:
                begin
                    // RAM read of this order's bin is issued here
                    if (ord_reg == '0)
                    begin
                        term_c_reg <= 17'sd32768;
                        term_s_reg <= '0;
                        state_reg  <= ST_ORD_WR;
                    end
                    else
                    begin
                        flip_reg  <= ang_flip;
                        cx_reg    <= 36'(GAIN_COMP_Q30);
                        cy_reg    <= '0;
                        cz_reg    <= signed'({{2{ang_fold[31]}}, ang_fold});
                        cnt_reg   <= '0;
                        state_reg <= ST_SC;
                    end
                end

                ST_SC:
                begin
                    // rotation: drive z toward zero
                    if (!cz_reg[33])
                    begin
                        cx_reg <= cx_reg - sh_y;
                        cy_reg <= cy_reg + sh_x;
                        cz_reg <= cz_reg - at_ext;
                    end
                    else
                    begin
                        cx_reg <= cx_reg + sh_y;
                        cy_reg <= cy_reg - sh_x;
                        cz_reg <= cz_reg + at_ext;
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 5'(CORDIC_ITER - 1))
                    begin
                        state_reg <= ST_SC_END;
                    end
                end

                ST_SC_END:
                begin
                    term_c_reg <= to_term(flip_reg ? -cx_reg : cx_reg);
                    term_s_reg <= to_term(flip_reg ? -cy_reg : cy_reg);
                    state_reg  <= ST_ORD_WR;
                end

                ST_ORD_WR:
                begin
                    tot_c_reg[tot_idx] <= sat40(tot_c_reg[tot_idx], term_c_reg);
                    tot_s_reg[tot_idx] <= sat40(tot_s_reg[tot_idx], term_s_reg);
                    ord_reg <= ord_reg + 1'b1;
                    ang_reg <= ang_reg + phi_reg;
                    if (ord_reg + 1'b1 == norders)
                    begin
                        acc_ok_reg <= 1'b1;
                        state_reg  <= ST_DONE;
                    end
                    else
                    begin
                        state_reg <= ST_ORD_START;
                    end
                end

                ST_RD:
                begin
                    state_reg <= ST_DONE;
                end

                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_DONE) && out_free)
        begin
            out_data_reg <= res;
        end
    end

    // the power-up sweep runs once only
    `ASSERT_NXT(a_init_once, clk, rst_n, state_reg != ST_INIT, state_reg != ST_INIT)
    // the order loop never runs past the active order count
    `ASSERT_IMP(a_ord_range, clk, rst_n, state_reg == ST_ORD_START, ord_reg < norders)
    // bin index is clamped before any accumulator write
    `ASSERT_IMP(a_bin_clamp, clk, rst_n, state_reg == ST_ORD_WR,
                int'(bin_reg) <= NUM_BINS - 1)
    // a finished item is never overwritten while the receiver stalls
    `ASSERT_NXT(a_out_hold, clk, rst_n, out_valid_reg && out_stall,
                out_valid_reg && $stable(out_data_reg))

endmodule

[src/fqva_ram.sv]
module fqva_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import fqva_pkg::*;

    // Clock and reset
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // DUT ports: every input starts at a known value
    logic      in_valid  = 1'b0;
    logic      in_stall;
    in_item_t  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_data;
    logic        cfg_write = 1'b0;
    logic [2:0]  cfg_index = CFG_RAPIDITY_MODE;
    logic [23:0] cfg_data  = '0;

    flow_qvector_accumulator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    localparam longint SUM_MAX = 64'sd549755813887;
    localparam longint SUM_MIN = -SUM_MAX - 1;
    localparam longint TERM_ONE = 32768;
    localparam int     IN_W = $bits(in_item_t);

    // atan(2^-i) as 32-bit binary angles, for the first 16 CORDIC steps
    localparam logic [31:0] ANGLE_STEP [16] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
    };

    // Shadow of the block's configuration
    logic        mode_q;
    logic [23:0] y_lo_q, y_hi_q, pt_lo_q, pt_hi_q, inv_bw_q;
    logic [3:0]  orders_q;

    // Shadow accumulators
    longint cos_total [MAX_ORDERS];
    longint sin_total [MAX_ORDERS];
    longint cos_binned [MAX_ORDERS*NUM_BINS];
    longint sin_binned [MAX_ORDERS*NUM_BINS];

    out_item_t pending_results [$];
    int        errors = 0;
    bit        quiet  = 1'b0;   // no idling on either side when set

    function automatic longint sx24(logic [23:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned res, bit_v;
        res = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > n)
            bit_v = bit_v >> 2;
        while (bit_v != 0)
        begin
            if (n >= res + bit_v)
            begin
                n = n - (res + bit_v);
                res = (res >> 1) + bit_v;
            end
            else
                res = res >> 1;
            bit_v = bit_v >> 2;
        end
        return longint'(res);
    endfunction

    // log2 with 20 fraction bits, by normalize and repeated squaring
    function automatic longint log2_q20(longint unsigned x);
        int k;
        longint unsigned m;
        longint r;
        k = 0;
        while (k < 29 && (x >> (k + 1)) != 0)
            k++;
        m = x << (30 - k);
        r = longint'(k) << 20;
        for (int i = 19; i >= 0; i--)
        begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31))
            begin
                m = m >> 1;
                r = r + (longint'(1) << i);
            end
        end
        return r;
    endfunction

    function automatic longint rapidity_q16(longint unsigned num, longint unsigned den);
        longint d, r;
        longint unsigned mag;
        d = log2_q20(num) - log2_q20(den);
        mag = longint'(d < 0 ? -d : d) * 64'd744261118;
        r = longint'((mag + (64'd1 << 34)) >> 35);
        return d < 0 ? -r : r;
    endfunction

    function automatic logic [31:0] azimuth(longint py, longint px);
        longint x, y, z, nx;
        x = px * 256;
        y = py * 256;
        z = 0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = longint'(1) << 31;
        end
        for (int i = 0; i < 16; i++)
        begin
            if (y >= 0)
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + longint'(ANGLE_STEP[i]);
            end
            else
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - longint'(ANGLE_STEP[i]);
            end
            x = nx;
        end
        return z[31:0];
    endfunction

    function automatic longint q15_term(longint v);
        v = (v + (1 << 14)) >>> 15;
        if (v > TERM_ONE)
            v = TERM_ONE;
        if (v < -TERM_ONE)
            v = -TERM_ONE;
        return v;
    endfunction

    task automatic harmonic_terms(input logic [31:0] t, output longint c, output longint s);
        logic flip;
        longint x, y, z, nx;
        flip = (t[31:30] == 2'd1) || (t[31:30] == 2'd2);
        x = 652032874;
        y = 0;
        if (flip)
            t = t + 32'h80000000;
        z = longint'(signed'(t));
        for (int i = 0; i < 16; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - longint'(ANGLE_STEP[i]);
            end
            else
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + longint'(ANGLE_STEP[i]);
            end
            x = nx;
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        c = q15_term(x);
        s = q15_term(y);
    endtask

    function automatic longint sat_sum(longint a, longint b);
        longint r;
        r = a + b;
        if (r > SUM_MAX)
            r = SUM_MAX;
        if (r < SUM_MIN)
            r = SUM_MIN;
        return r;
    endfunction

    function automatic void zero_sums();
        foreach (cos_total[i])
        begin
            cos_total[i] = 0;
            sin_total[i] = 0;
        end
        foreach (cos_binned[i])
        begin
            cos_binned[i] = 0;
            sin_binned[i] = 0;
        end
    endfunction

    // Predicts the result of one item and advances the shadow sums.
    task automatic flow_predict(input in_item_t it, output out_item_t r);
        longint px, py, pz, y, pt, bin, norders, c, s, idx;
        longint unsigned e, m, a, apz;
        logic [31:0] phi;
        r = '0;
        case (it.func)
            FUNC_READ:
            begin
                r.total_real = cos_total[it.read_order][39:0];
                r.total_imag = sin_total[it.read_order][39:0];
                r.bin_real   = cos_binned[it.read_order*NUM_BINS + it.read_bin][39:0];
                r.bin_imag   = sin_binned[it.read_order*NUM_BINS + it.read_bin][39:0];
            end
            FUNC_CLEAR:
                zero_sums();
            FUNC_ACC:
            begin
                px = sx24(it.mom_x);
                py = sx24(it.mom_y);
                pz = sx24(it.mom_z);
                e  = it.energy;
                m  = it.rest_mass;
                if (mode_q == 1'b0)
                begin
                    if (m > e)
                        return;
                    a = int_sqrt(e*e - m*m);
                end
                else
                    a = e;
                apz = pz < 0 ? -pz : pz;
                if (a <= apz)
                    return;
                y = rapidity_q16(a + pz, a - pz);
                if (!(y > sx24(y_lo_q) && y < sx24(y_hi_q)))
                    return;
                pt = int_sqrt(px*px + py*py);
                if (!(pt > pt_lo_q && pt < pt_hi_q))
                    return;
                bin = ((pt - pt_lo_q) * longint'(inv_bw_q)) >>> 32;
                if (bin > NUM_BINS - 1)
                    bin = NUM_BINS - 1;
                phi = azimuth(py, px);
                norders = orders_q > MAX_ORDERS ? MAX_ORDERS : orders_q;
                for (longint n = 0; n < norders; n++)
                begin
                    c = TERM_ONE;
                    s = 0;
                    if (n != 0)
                        harmonic_terms(phi * n[31:0], c, s);
                    idx = n*NUM_BINS + bin;
                    cos_total[n]    = sat_sum(cos_total[n], c);
                    sin_total[n]    = sat_sum(sin_total[n], s);
                    cos_binned[idx] = sat_sum(cos_binned[idx], c);
                    sin_binned[idx] = sat_sum(sin_binned[idx], s);
                end
                r.accepted  = 1'b1;
                r.bin_index = bin[5:0];
            end
            default: ;
        endcase
    endtask

    // Mostly no gap, some short, a few long
    function automatic int gap_len();
        int p;
        if (quiet)
            return 0;
        p = $urandom_range(0, 99);
        if (p < 65)
            return 0;
        if (p < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Output side: random stall stretches
    int stall_left = 0;
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            stall_left <= gap_len();
            out_stall <= 1'b0;
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        out_item_t want;
        if (out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected item %p", $time, out_data);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_data.accepted !== want.accepted)
                begin
                    $display("%0t: accepted exp %0d got %0d", $time, want.accepted,
                             out_data.accepted);
                    errors++;
                end
                if (out_data.bin_index !== want.bin_index)
                begin
                    $display("%0t: bin_index exp %0d got %0d", $time, want.bin_index,
                             out_data.bin_index);
                    errors++;
                end
                if (out_data.total_real !== want.total_real)
                begin
                    $display("%0t: total_real exp %0d got %0d", $time, want.total_real,
                             out_data.total_real);
                    errors++;
                end
                if (out_data.total_imag !== want.total_imag)
                begin
                    $display("%0t: total_imag exp %0d got %0d", $time, want.total_imag,
                             out_data.total_imag);
                    errors++;
                end
                if (out_data.bin_real !== want.bin_real)
                begin
                    $display("%0t: bin_real exp %0d got %0d", $time, want.bin_real,
                             out_data.bin_real);
                    errors++;
                end
                if (out_data.bin_imag !== want.bin_imag)
                begin
                    $display("%0t: bin_imag exp %0d got %0d", $time, want.bin_imag,
                             out_data.bin_imag);
                    errors++;
                end
            end
        end
    end

    // Presents one item, waits for the handshake, queues its expected result.
    // A typed row queues its fixed answer; the predictor still tracks state.
    task automatic send_item(input in_item_t it, input bit typed, input out_item_t fixed);
        out_item_t r;
        int n;
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (in_stall);
        flow_predict(it, r);
        pending_results.push_back(typed ? fixed : r);
        n = gap_len();
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Lower valid and wait until every result is back
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [23:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_RAPIDITY_MODE: mode_q   = val[0];
            CFG_RAPIDITY_LOW:  y_lo_q   = val;
            CFG_RAPIDITY_HIGH: y_hi_q   = val;
            CFG_PT_LOW:        pt_lo_q  = val;
            CFG_PT_HIGH:       pt_hi_q  = val;
            CFG_INV_BIN_WIDTH: inv_bw_q = val;
            CFG_ORDERS_IN_USE: orders_q = val[3:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic mode, input logic [23:0] ylo, input logic [23:0] yhi,
                             input logic [23:0] ptlo, input logic [23:0] pthi,
                             input logic [23:0] ibw, input logic [3:0] ords);
        reg_write(CFG_RAPIDITY_MODE, {23'd0, mode});
        reg_write(CFG_RAPIDITY_LOW, ylo);
        reg_write(CFG_RAPIDITY_HIGH, yhi);
        reg_write(CFG_PT_LOW, ptlo);
        reg_write(CFG_PT_HIGH, pthi);
        reg_write(CFG_INV_BIN_WIDTH, ibw);
        reg_write(CFG_ORDERS_IN_USE, {20'd0, ords});
        cfg_write <= 1'b0;
    endtask

    // A physical particle: mass below energy, |pz| well below |p|,
    // transverse momentum spread around the current pT window.
    function automatic in_item_t make_particle();
        in_item_t it;
        int unsigned lim, e;
        it = '0;
        it.func = FUNC_ACC;
        lim = (pt_hi_q > 24'h3FFFFF) ? 24'h3FFFFF : pt_hi_q + 1;
        it.mom_x = 24'($urandom_range(0, 2*lim) - lim);
        it.mom_y = 24'($urandom_range(0, 2*lim) - lim);
        e = $urandom_range(1 << 15, 1 << 21);
        it.energy = e[23:0];
        it.rest_mass = 24'($urandom_range(0, e/2));
        it.mom_z = 24'($urandom_range(0, 2*(e/3)) - e/3);
        it.read_order = 3'($urandom);
        it.read_bin = 6'($urandom);
        return it;
    endfunction

    function automatic in_item_t make_item();
        in_item_t it;
        int p;
        p = $urandom_range(0, 999);
        if (p < 600)
            return make_particle();
        it = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
        if (p < 880)
            it.func = FUNC_READ;
        else if (p < 884)
            it.func = FUNC_CLEAR;
        else if (p < 900)
            it.func = FUNC_NONE;
        else
            it.func = FUNC_ACC;   // raw noise particle, mostly rejected
        return it;
    endfunction

    // Directed rows, run with the reset configuration
    typedef struct {
        in_item_t  item;
        bit        typed;
        out_item_t fixed;
    } drow_t;

    function automatic in_item_t pkt(logic [1:0] f, int x, int y, int z, int e, int m,
                                     int ro, int rb);
        in_item_t it;
        it.func       = f;
        it.mom_x      = x[23:0];
        it.mom_y      = y[23:0];
        it.mom_z      = z[23:0];
        it.energy     = e[23:0];
        it.rest_mass  = m[23:0];
        it.read_order = ro[2:0];
        it.read_bin   = rb[5:0];
        return it;
    endfunction

    drow_t drows [$];

    initial
    begin
        int n_random;
        mode_q   = 1'b0;
        y_lo_q   = 24'hFF0000;
        y_hi_q   = 24'd65536;
        pt_lo_q  = 24'd0;
        pt_hi_q  = 24'd196608;
        inv_bw_q = 24'd1310720;
        orders_q = 4'd8;
        zero_sums();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sums are zero after reset
        drows.push_back('{pkt(FUNC_READ, 0, 0, 0, 0, 0, 0, 0), 1, '0});
        // Unused function code with every field at its top
        drows.push_back('{pkt(FUNC_NONE, -1, -1, -1, -1, -1, 7, 63), 1, '0});
        // Simple particle along +x
        drows.push_back('{pkt(FUNC_ACC, 65536, 0, 0, 131072, 65536, 0, 0), 0, '0});
        // Mass above energy is rejected
        drows.push_back('{pkt(FUNC_ACC, 65536, 0, 0, 65536, 131072, 0, 0), 1, '0});
        // Mass equal to energy gives |p| = 0: zero denominator
        drows.push_back('{pkt(FUNC_ACC, 65536, 0, 0, 65536, 65536, 0, 0), 1, '0});
        drows.push_back('{pkt(FUNC_ACC, 0, 0, 0, 16777215, 16777215, 0, 0), 1, '0});
        // Other quadrants and axes
        drows.push_back('{pkt(FUNC_ACC, -70000, -40000, 3000, 200000, 1000, 0, 0), 0, '0});
        drows.push_back('{pkt(FUNC_ACC, 0, -65536, -5000, 140000, 20000, 0, 0), 0, '0});
        drows.push_back('{pkt(FUNC_ACC, -100000, 0, 9000, 160000, 0, 0, 0), 0, '0});
        drows.push_back('{pkt(FUNC_ACC, 0, 120000, 0, 130000, 0, 0, 0), 0, '0});
        // Momentum extremes: fails the pT window
        drows.push_back('{pkt(FUNC_ACC, 8388607, -8388608, -8388608, 16777215, 0, 0, 0), 0, '0});
        // pT just under the window top lands in a high bin
        drows.push_back('{pkt(FUNC_ACC, 196000, 0, 0, 200000, 0, 0, 0), 0, '0});
        // Reads: integrated, binned, top indexes
        drows.push_back('{pkt(FUNC_READ, 0, 0, 0, 0, 0, 0, 0), 0, '0});
        drows.push_back('{pkt(FUNC_READ, 0, 0, 0, 0, 0, 1, 0), 0, '0});
        drows.push_back('{pkt(FUNC_READ, 0, 0, 0, 0, 0, 2, 19), 0, '0});
        drows.push_back('{pkt(FUNC_READ, 0, 0, 0, 0, 0, 7, 63), 0, '0});
        // Clear, then the reads come back zero
        drows.push_back('{pkt(FUNC_CLEAR, 5, 5, 5, 5, 5, 1, 1), 1, '0});
        drows.push_back('{pkt(FUNC_READ, 0, 0, 0, 0, 0, 0, 0), 1, '0});
        drows.push_back('{pkt(FUNC_READ, 0, 0, 0, 0, 0, 7, 63), 1, '0});

        foreach (drows[i])
            send_item(drows[i].item, drows[i].typed, drows[i].fixed);
        drain();

        // Random phases over several register settings
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: configure(1'b0, 24'hFF0000, 24'd65536, 24'd0, 24'd196608,
                             24'd1310720, 4'd8);
                1: configure(1'b1, 24'h800000, 24'h7FFFFF, 24'd0, 24'hFFFFFF,
                             24'hFFFFFF, 4'd15);
                2: configure(1'b0, 24'd0, 24'd32768, 24'd32768, 24'd131072,
                             24'd0, 4'd1);
                3: configure(1'b1, 24'hFE0000, 24'd131072, 24'd16384, 24'd262144,
                             24'd2000000, 4'd0);
                4: configure(1'b0, 24'h7FFFFF, 24'h800000, 24'hFFFFFF, 24'd0,
                             24'd65536, 4'd8);
                default: configure(1'($urandom), 24'($urandom_range(0, 98304) - 98304),
                                   24'($urandom_range(0, 98304)), 24'($urandom_range(0, 65536)),
                                   24'($urandom_range(100000, 600000)),
                                   24'($urandom), 4'($urandom));
            endcase
            quiet = (ph == 2);
            n_random = (ph == 4) ? 60 : 180;
            for (int i = 0; i < n_random; i++)
                send_item(make_item(), 0, '0);
            drain();
        end

        quiet = 1'b0;
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Run limit
    initial
    begin
        #50_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
